[src/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
// No dependencies; every file but bba_ram imports this package.
package bba_pkg;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam int BS_W      = 21;
    localparam int DATA_W    = 32;
    localparam int ARG_W     = 17;
    localparam int TOTAL_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_SIZE = 2'd1,
        ST_NO_FIT    = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_REPORT  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        status_t          status;
        logic [ARG_W-1:0] arg;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } back_stat_t;

    function automatic logic [BS_W-1:0] eff_bs(input logic [BS_W-1:0] bs);
        return (bs == '0) ? BS_W'(1) : bs;
    endfunction

endpackage

[src/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/bba_front.sv]
// Front end: accepts requests, checks ranges and divides by the block size.
// Depends on bba_pkg.
module bba_front #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [31:0]                s_request_size,
    input  logic [31:0]                s_release_address,
    input  logic [bba_pkg::BS_W-1:0]   block_size,
    input  logic [31:0]                region_start,
    input  logic [31:0]                region_end,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output bba_pkg::cmd_t              cmd
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_DIV   = 4'b0010,
        F_CLASS = 4'b0100,
        F_PUSH  = 4'b1000
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic              func_reg;
    logic [31:0]       dvd_reg;
    logic [BS_W-1:0]   rem_reg;
    logic [BS_W-1:0]   bs_reg;
    logic [4:0]        cnt_reg;
    cmd_t              cmd_reg;
    logic [BS_W:0]     trial;
    logic              ge;
    logic [32:0]       need33;

    assign s_ready   = (state_reg == F_IDLE);
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd       = cmd_reg;

    assign trial  = {rem_reg, dvd_reg[31]};
    assign ge     = (trial >= {1'b0, bs_reg});
    assign need33 = {1'b0, dvd_reg} + {32'd0, (rem_reg != '0)};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_ALLOC && s_request_size == '0) begin
                        state_next = F_PUSH;
                    end else if (s_func == FUNC_RELEASE &&
                                 (s_release_address < region_start ||
                                  s_release_address >= region_end)) begin
                        state_next = F_PUSH;
                    end else begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV: begin
                if (cnt_reg == 5'd31) begin
                    state_next = F_CLASS;
                end
            end
            F_CLASS: state_next = F_PUSH;
            F_PUSH: begin
                if (cmd_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                func_reg <= s_func;
                bs_reg   <= eff_bs(block_size);
                rem_reg  <= '0;
                cnt_reg  <= '0;
                dvd_reg  <= (s_func == FUNC_ALLOC) ? s_request_size
                                                   : s_release_address - region_start;
                cmd_reg.op  <= OP_REPORT;
                cmd_reg.arg <= '0;
                cmd_reg.status <= (s_func == FUNC_ALLOC) ? ST_ZERO_SIZE : ST_RANGE;
            end
            F_DIV: begin
                rem_reg <= ge ? BS_W'(trial - {1'b0, bs_reg}) : BS_W'(trial);
                dvd_reg <= {dvd_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
            F_CLASS: begin
                if (func_reg == FUNC_ALLOC) begin
                    if (need33 > 33'(NUM_BLOCKS)) begin
                        cmd_reg.op     <= OP_REPORT;
                        cmd_reg.status <= ST_NO_FIT;
                    end else begin
                        cmd_reg.op     <= OP_ALLOC;
                        cmd_reg.status <= ST_OK;
                    end
                    cmd_reg.arg <= ARG_W'(need33);
                end else begin
                    if (dvd_reg >= 32'(NUM_BLOCKS)) begin
                        cmd_reg.op     <= OP_REPORT;
                        cmd_reg.status <= ST_RANGE;
                    end else begin
                        cmd_reg.op     <= OP_RELEASE;
                        cmd_reg.status <= ST_OK;
                    end
                    cmd_reg.arg <= ARG_W'(dvd_reg);
                end
            end
            default: begin
            end
        endcase
    end
endmodule

[src/bba_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on bba_pkg.
module bba_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  bba_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output bba_pkg::cmd_t out_cmd
);
    import bba_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_cmd;
        end
    end
endmodule

[src/bba_back.sv]
// Back end: scans and updates the bitmap word by word and drives results.
// Depends on bba_pkg and bba_ram.
module bba_back #(
    parameter int NUM_BLOCKS = 1024,
    parameter int WORD_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  bba_pkg::cmd_t                cmd,
    input  logic [bba_pkg::BS_W-1:0]     block_size,
    input  logic [31:0]                  region_start,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [31:0]                  m_block_address,
    output logic [bba_pkg::TOTAL_W-1:0]  m_free_block_total,
    output bba_pkg::back_stat_t          stat
);
    import bba_pkg::*;

    localparam int NWORDS = NUM_BLOCKS / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int IW     = $clog2(NUM_BLOCKS);
    localparam int CW     = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [9:0] {
        B_CLEAR   = 10'b0000000001,
        B_IDLE    = 10'b0000000010,
        B_SCAN_RD = 10'b0000000100,
        B_SCAN_EV = 10'b0000001000,
        B_MARK_RD = 10'b0000010000,
        B_MARK_WR = 10'b0000100000,
        B_REL_RD  = 10'b0001000000,
        B_REL_WR  = 10'b0010000000,
        B_MUL     = 10'b0100000000,
        B_DONE    = 10'b1000000000
    } bstate_t;

    bstate_t              state_reg;
    logic [AW-1:0]        wa_reg;
    logic [CW-1:0]        need_reg, run_reg, count_reg;
    logic [IW-1:0]        lo_reg, hi_reg;
    logic [IW+BS_W-1:0]   prod_reg;
    status_t              st_reg;
    logic                 ok_alloc_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [31:0]          m_addr_reg;
    logic [TOTAL_W-1:0]   m_total_reg;

    logic                 we;
    logic [WORD_BITS-1:0] wdata, rdata;
    logic [CW-1:0]        run_at [WORD_BITS];
    logic                 hit;
    logic [BW-1:0]        hit_pos;
    logic [WORD_BITS-1:0] mark_mask;
    logic [IW:0]          start_calc;

    bba_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_map (
        .aclk  (aclk),
        .we    (we),
        .waddr (wa_reg),
        .wdata (wdata),
        .raddr (wa_reg),
        .rdata (rdata)
    );

    always_comb begin
        logic [CW-1:0] r;
        logic [IW-1:0] g;
        hit     = 1'b0;
        hit_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            r = run_reg + CW'(j + 1);
            for (int k = 0; k <= j; k++) begin
                if (rdata[k]) begin
                    r = CW'(j - k);
                end
            end
            run_at[j] = r;
        end
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (run_at[j] >= need_reg) begin
                hit     = 1'b1;
                hit_pos = BW'(j);
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            g = IW'({wa_reg, BW'(j)});
            mark_mask[j] = (g >= lo_reg) && (g <= hi_reg);
        end
        start_calc = (IW + 1)'({wa_reg, hit_pos}) + (IW + 1)'(1) - (IW + 1)'(need_reg);
    end

    always_comb begin
        we    = 1'b0;
        wdata = rdata;
        case (state_reg)
            B_CLEAR: begin
                we    = 1'b1;
                wdata = '0;
            end
            B_MARK_WR: begin
                we    = 1'b1;
                wdata = rdata | mark_mask;
            end
            B_REL_WR: begin
                we    = 1'b1;
                wdata = rdata & ~(WORD_BITS'(1) << lo_reg[BW-1:0]);
            end
            default: begin
            end
        endcase
    end

    assign cmd_ready          = (state_reg == B_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_block_address    = m_addr_reg;
    assign m_free_block_total = m_total_reg;
    assign stat.clearing      = (state_reg == B_CLEAR);
    assign stat.busy          = (state_reg != B_IDLE) && (state_reg != B_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            wa_reg      <= '0;
            count_reg   <= CW'(NUM_BLOCKS);
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != B_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR: begin
                    if (wa_reg == AW'(NWORDS - 1)) begin
                        state_reg <= B_IDLE;
                    end else begin
                        wa_reg <= wa_reg + AW'(1);
                    end
                end
                B_IDLE: begin
                    if (cmd_valid) begin
                        st_reg       <= cmd.status;
                        ok_alloc_reg <= 1'b0;
                        need_reg     <= CW'(cmd.arg);
                        run_reg      <= '0;
                        lo_reg       <= IW'(cmd.arg);
                        case (cmd.op)
                            OP_ALLOC: begin
                                wa_reg    <= '0;
                                state_reg <= B_SCAN_RD;
                            end
                            OP_RELEASE: begin
                                wa_reg    <= AW'(IW'(cmd.arg) >> BW);
                                state_reg <= B_REL_RD;
                            end
                            default: state_reg <= B_DONE;
                        endcase
                    end
                end
                B_SCAN_RD: state_reg <= B_SCAN_EV;
                B_SCAN_EV: begin
                    if (hit) begin
                        lo_reg    <= IW'(start_calc);
                        hi_reg    <= IW'(start_calc + (IW + 1)'(need_reg) - (IW + 1)'(1));
                        wa_reg    <= AW'(IW'(start_calc) >> BW);
                        state_reg <= B_MARK_RD;
                    end else begin
                        run_reg <= run_at[WORD_BITS-1];
                        if (wa_reg == AW'(NWORDS - 1)) begin
                            st_reg    <= ST_NO_FIT;
                            state_reg <= B_DONE;
                        end else begin
                            wa_reg    <= wa_reg + AW'(1);
                            state_reg <= B_SCAN_RD;
                        end
                    end
                end
                B_MARK_RD: state_reg <= B_MARK_WR;
                B_MARK_WR: begin
                    if (wa_reg == AW'(hi_reg >> BW)) begin
                        state_reg <= B_MUL;
                    end else begin
                        wa_reg    <= wa_reg + AW'(1);
                        state_reg <= B_MARK_RD;
                    end
                end
                B_MUL: begin
                    ok_alloc_reg <= 1'b1;
                    count_reg    <= (count_reg >= need_reg) ? count_reg - need_reg : '0;
                    state_reg    <= B_DONE;
                end
                B_REL_RD: state_reg <= B_REL_WR;
                B_REL_WR: begin
                    if (count_reg < CW'(NUM_BLOCKS)) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= B_DONE;
                end
                B_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_MUL) begin
            prod_reg <= lo_reg * eff_bs(block_size);
        end
        if (state_reg == B_DONE && (!m_valid_reg || m_ready)) begin
            m_status_reg <= st_reg;
            m_addr_reg   <= ok_alloc_reg ? region_start + 32'(prod_reg) : 32'd0;
            m_total_reg  <= TOTAL_W'(count_reg);
        end
    end
endmodule

[src/bitmap_block_allocator.sv]
// First-fit contiguous block allocator over a used/free bitmap.
// Requests pass through the front end (range checks and a bit-serial division) and a two-entry
// queue to the back end, which scans the bitmap word by word and marks the words of a fit for
// an allocate, or clears one bit for a release. Front and back end each take one item at a time.
// After reset a clearing pass over all NUM_BLOCKS/WORD_BITS bitmap words runs before any transfer.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 1024,
    parameter int WORD_BITS  = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [31:0]                     s_request_size,
    input  logic [31:0]                     s_release_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [31:0]                     m_block_address,
    output logic [bba_pkg::TOTAL_W-1:0]     m_free_block_total
);
    import bba_pkg::*;

    logic [BS_W-1:0] block_size_reg;
    logic [31:0]     region_start_reg, region_end_reg;
    logic            front_ready, front_valid;
    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t            fq_cmd, qb_cmd;
    back_stat_t      stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg   <= BS_W'(4096);
            region_start_reg <= 32'd0;
            region_end_reg   <= 32'd4194304;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BLOCK_SIZE:   block_size_reg   <= cfg_wdata[BS_W-1:0];
                CFG_REGION_START: region_start_reg <= cfg_wdata;
                CFG_REGION_END:   region_end_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready     = front_ready && !stat.clearing;
    assign front_valid = s_valid && !stat.clearing;

    bba_front #(.NUM_BLOCKS(NUM_BLOCKS)) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (front_valid),
        .s_ready           (front_ready),
        .s_func            (s_func),
        .s_request_size    (s_request_size),
        .s_release_address (s_release_address),
        .block_size        (block_size_reg),
        .region_start      (region_start_reg),
        .region_end        (region_end_reg),
        .cmd_valid         (fq_valid),
        .cmd_ready         (fq_ready),
        .cmd               (fq_cmd)
    );

    bba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    bba_back #(.NUM_BLOCKS(NUM_BLOCKS), .WORD_BITS(WORD_BITS)) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_valid          (qb_valid),
        .cmd_ready          (qb_ready),
        .cmd                (qb_cmd),
        .block_size         (block_size_reg),
        .region_start       (region_start_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_block_address    (m_block_address),
        .m_free_block_total (m_free_block_total),
        .stat               (stat)
    );

    a_err_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_block_address == 32'd0)
        else $error("Failed request carries a nonzero address.");

    a_clear_blocks_input: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("Input ready during the bitmap clearing pass.");

    a_clear_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clearing |-> !qb_ready && !stat.busy)
        else $error("Back end active during the clearing pass.");
endmodule

[tb/bitmap_block_allocator_test.sv]
// Self-checking testbench for the bitmap block allocator: random allocate and release
// transfers against a first-fit bitmap predictor. Depends on bba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module bitmap_block_allocator_test;
    import bba_pkg::*;

    localparam int NBLK = 1024;

    typedef struct {
        logic        func;
        logic [31:0] size;
        logic [31:0] addr;
    } req_t;

    typedef struct {
        status_t     status;
        logic [31:0] addr;
        logic [10:0] total;
    } resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = 1'b0;
    logic [31:0] s_request_size = '0;
    logic [31:0] s_release_address = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic [31:0] m_block_address;
    logic [TOTAL_W-1:0] m_free_block_total;

    bitmap_block_allocator dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    req_t pending_reqs[$];
    resp_t expected_resps[$];
    logic used_bits[NBLK];
    int free_count;
    logic [20:0] blk_size;
    logic [31:0] reg_start, reg_end;
    int errors = 0;
    bit calm = 0;
    bit hold_off = 0;
    int live_starts[$];

    function automatic resp_t predict_request(req_t r);
        resp_t o;
        longint bs, need, run, first, idx;
        bs = (blk_size == 0) ? 1 : blk_size;
        o.addr = '0;
        if (r.func == FUNC_ALLOC) begin
            if (r.size == 0) o.status = ST_ZERO_SIZE;
            else begin
                need = (longint'(r.size) + bs - 1) / bs;
                run = 0; first = 0;
                if (need <= NBLK) begin
                    for (int k = 0; k < NBLK; k++) begin
                        if (!used_bits[k]) begin
                            if (run == 0) first = k;
                            run++;
                            if (run == need) break;
                        end else run = 0;
                    end
                end
                if (need > NBLK || run != need) o.status = ST_NO_FIT;
                else begin
                    for (longint k = first; k < first + need; k++) used_bits[k] = 1'b1;
                    free_count = (free_count >= need) ? free_count - int'(need) : 0;
                    o.status = ST_OK;
                    o.addr = 32'(longint'(reg_start) + first * bs);
                    live_starts.push_back(int'(first));
                end
            end
        end else begin
            if (r.addr < reg_start || r.addr >= reg_end) o.status = ST_RANGE;
            else begin
                idx = longint'(r.addr - reg_start) / bs;
                if (idx >= NBLK) o.status = ST_RANGE;
                else begin
                    used_bits[idx] = 1'b0;
                    if (free_count < NBLK) free_count++;
                    o.status = ST_OK;
                end
            end
        end
        o.total = 11'(free_count);
        return o;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_resps.push_back(predict_request(pending_reqs.pop_front()));
            end
            if ((!s_valid || s_ready) && pending_reqs.size() > 0
                && !hold_off && (calm || $urandom_range(99) >= 15)) begin
                s_valid <= 1'b1;
                s_func <= pending_reqs[0].func;
                s_request_size <= pending_reqs[0].size;
                s_release_address <= pending_reqs[0].addr;
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t: unexpected result status=%0d addr=%h total=%0d", $time,
                             m_status, m_block_address, m_free_block_total);
                    errors++;
                end else begin
                    resp_t e;
                    e = expected_resps.pop_front();
                    if (m_status !== e.status || m_block_address !== e.addr
                        || m_free_block_total !== e.total) begin
                        $display("%0t: mismatch expected %0d/%h/%0d actual %0d/%h/%0d",
                                 $time, e.status, e.addr, e.total, m_status,
                                 m_block_address, m_free_block_total);
                        errors++;
                    end
                end
            end
            m_ready <= calm || $urandom_range(99) >= 15;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_BLOCK_SIZE: blk_size = val[20:0];
            CFG_REGION_START: reg_start = val;
            default: reg_end = val;
        endcase
    endtask

    task automatic queue_req(logic func, logic [31:0] size, logic [31:0] addr);
        req_t r;
        r.func = func; r.size = size; r.addr = addr;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || s_valid || expected_resps.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        longint bs;
        bs = (blk_size == 0) ? 1 : blk_size;
        for (int i = 0; i < n; i++) begin
            int c;
            c = $urandom_range(99);
            if (c < 45) queue_req(FUNC_ALLOC, $urandom_range(1, 40) * 32'(bs)
                                  - $urandom_range(0, 1), $urandom());
            else if (c < 80 && live_starts.size() > 0) begin
                int j;
                j = $urandom_range(live_starts.size() - 1);
                queue_req(FUNC_RELEASE, $urandom(),
                          32'(longint'(reg_start) + live_starts[j] * bs
                              + $urandom_range(0, 32'(bs) - 1)));
                live_starts.delete(j);
            end else if (c < 88) queue_req(FUNC_RELEASE, $urandom(), $urandom());
            else if (c < 93) queue_req(FUNC_ALLOC, $urandom(), $urandom());
            else if (c < 96) queue_req(FUNC_ALLOC, 32'd0, $urandom());
            else queue_req(FUNC_RELEASE, $urandom(),
                           32'(longint'(reg_start) + $urandom_range(0, NBLK - 1) * bs));
        end
    endtask

    initial begin
        for (int k = 0; k < NBLK; k++) used_bits[k] = 1'b0;
        free_count = NBLK;
        blk_size = 21'd4096; reg_start = 32'd0; reg_end = 32'd4194304;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        queue_req(FUNC_ALLOC, 32'd0, 32'hFFFF_FFFF);
        queue_req(FUNC_ALLOC, 32'd1, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4096, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4097, 32'd0);
        queue_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0);
        queue_req(FUNC_ALLOC, 32'h8000_0000, 32'd0);
        queue_req(FUNC_RELEASE, 32'hFFFF_FFFF, 32'd4096);
        queue_req(FUNC_RELEASE, 32'd0, 32'd4096);
        queue_req(FUNC_RELEASE, 32'd0, 32'd4194304);
        queue_req(FUNC_RELEASE, 32'd0, 32'hFFFF_FFFF);
        queue_req(FUNC_RELEASE, 32'd0, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4194304, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4096, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4194304, 32'd0);
        queue_req(FUNC_RELEASE, 32'd0, 32'd8192);
        queue_req(FUNC_ALLOC, 32'd8192, 32'd0);
        queue_req(FUNC_ALLOC, 32'd4096, 32'd0);
        drain_all();

        write_reg(CFG_BLOCK_SIZE, 32'd0);
        write_reg(CFG_REGION_START, 32'hFFFF_FF00);
        write_reg(CFG_REGION_END, 32'hFFFF_FFFF);
        queue_req(FUNC_RELEASE, 32'd0, 32'hFFFF_FF10);
        queue_req(FUNC_RELEASE, 32'd0, 32'hFFFF_FEFF);
        random_phase(150);
        drain_all();

        calm = 1;
        write_reg(CFG_BLOCK_SIZE, 32'd1048576);
        write_reg(CFG_REGION_START, 32'h1234_0000);
        write_reg(CFG_REGION_END, 32'hFFFF_FFFF);
        random_phase(150);
        drain_all();
        calm = 0;

        write_reg(CFG_BLOCK_SIZE, 32'd64);
        write_reg(CFG_REGION_START, 32'h0001_0000);
        write_reg(CFG_REGION_END, 32'h0001_8000);
        random_phase(100);
        drain_all();
        hold_off = 1;
        random_phase(10);
        hold_off = 0;
        drain_all();

        write_reg(CFG_BLOCK_SIZE, 32'h1F_FFFF);
        write_reg(CFG_REGION_START, 32'd0);
        write_reg(CFG_REGION_END, 32'hFFFF_FFFF);
        random_phase(200);
        drain_all();

        if (errors == 0) begin
            $display("** bitmap_block_allocator: PASSED **");
        end else begin
            $display("** bitmap_block_allocator: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** bitmap_block_allocator: FAILED **");
        $finish;
    end
endmodule
